// ===== sv/spmmu_pkg.sv =====
// ----------------------------------------------------------------------------
// spmmu_pkg: shared types and constants of the segment/page MMU
// Field widths, memory geometry, command and status codes, TLB request types.
// ----------------------------------------------------------------------------
package spmmu_pkg;

  // Memory geometry
  localparam int FRAME_WORDS  = 512;
  localparam int MEMORY_WORDS = 524288;
  localparam int FRAME_COUNT  = MEMORY_WORDS / FRAME_WORDS;
  localparam int TLB_ENTRIES  = 4;

  localparam int PA_W    = $clog2(MEMORY_WORDS);   // word address
  localparam int WORD_W  = 20;                     // table word
  localparam int OFS_W   = $clog2(FRAME_WORDS);
  localparam int SEG_W   = 9;
  localparam int PAGE_W  = 10;
  localparam int VA_W    = SEG_W + PAGE_W + OFS_W;
  localparam int KEY_W   = SEG_W + PAGE_W;
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int AGE_W   = 2;
  localparam int IDX_W   = $clog2(TLB_ENTRIES);

  // Frame bitmap held as words of 32 bits
  localparam int MAP_W   = 32;
  localparam int MAP_BW  = $clog2(MAP_W);
  localparam int MAP_AW  = $clog2(FRAME_COUNT / MAP_W);

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_SET_SEG  = 2'd2,
    CMD_SET_PAGE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_MISS       = 3'd1,
    ST_FAULT      = 3'd2,
    ST_ERROR      = 3'd3,
    ST_SET_DONE   = 3'd4,
    ST_SET_REJECT = 3'd5
  } status_t;

  typedef struct packed {
    logic             touch;
    logic             insert;
    logic [KEY_W-1:0] key;
    logic [PA_W-1:0]  frame;
  } tlb_req_t;

  typedef struct packed {
    logic            hit;
    logic [PA_W-1:0] frame;
  } tlb_rsp_t;

endpackage

// ===== sv/spmmu_ram.sv =====
// ----------------------------------------------------------------------------
// spmmu_ram: single-port synchronous RAM
// One access per cycle, read data registered (read-before-write).
// ----------------------------------------------------------------------------
module spmmu_ram #(
  parameter int ADDR_W = spmmu_pkg::PA_W,
  parameter int DATA_W = spmmu_pkg::WORD_W
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== sv/spmmu_tlb.sv =====
// ----------------------------------------------------------------------------
// spmmu_tlb: four-entry fully associative TLB with 2-bit age LRU
// Lookup is combinational on the key; touch and insert update at the edge.
// ----------------------------------------------------------------------------
module spmmu_tlb (
  input  logic                clk,
  input  logic                rst,
  input  spmmu_pkg::tlb_req_t req,
  output spmmu_pkg::tlb_rsp_t rsp
);

  localparam int N = spmmu_pkg::TLB_ENTRIES;

  logic [N-1:0]                   valid, valid_next;
  logic [spmmu_pkg::KEY_W-1:0]    key   [N];
  logic [spmmu_pkg::KEY_W-1:0]    key_next [N];
  logic [spmmu_pkg::PA_W-1:0]     frm   [N];
  logic [spmmu_pkg::PA_W-1:0]     frm_next [N];
  logic [spmmu_pkg::AGE_W-1:0]    age   [N];
  logic [spmmu_pkg::AGE_W-1:0]    age_next [N];
  logic [N-1:0]                   match;
  logic [spmmu_pkg::IDX_W-1:0]    hit_idx;
  logic [spmmu_pkg::AGE_W-1:0]    hit_age;

  // Lookup: lowest matching entry wins
  always_comb begin
    hit_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      match[i] = valid[i] && (key[i] == req.key);
      if (match[i]) begin
        hit_idx = spmmu_pkg::IDX_W'(i);
      end
    end
  end

  assign hit_age   = age[hit_idx];
  assign rsp.hit   = |match;
  assign rsp.frame = frm[hit_idx];

  // Touch ages younger-than-hit entries; insert fills first free slot,
  // replacing every oldest entry met before it
  always_comb begin
    logic stop;
    stop       = 1'b0;
    valid_next = valid;
    for (int i = 0; i < N; i++) begin
      key_next[i] = key[i];
      frm_next[i] = frm[i];
      age_next[i] = age[i];
    end
    if (req.touch && rsp.hit) begin
      for (int j = 0; j < N; j++) begin
        if (valid[j] && (age[j] > hit_age)) begin
          age_next[j] = age[j] - 1'b1;
        end
      end
      age_next[hit_idx] = '1;
    end else if (req.insert) begin
      for (int i = 0; i < N; i++) begin
        if (!stop) begin
          if (valid[i]) begin
            if (age[i] == '0) begin
              age_next[i] = '1;
              key_next[i] = req.key;
              frm_next[i] = req.frame;
            end else begin
              age_next[i] = age[i] - 1'b1;
            end
          end else begin
            valid_next[i] = 1'b1;
            age_next[i]   = '1;
            key_next[i]   = req.key;
            frm_next[i]   = req.frame;
            stop          = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      key[i] <= key_next[i];
      frm[i] <= frm_next[i];
      age[i] <= age_next[i];
    end
  end

  // Entries are never invalidated after reset
  a_valid_grows: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> $countones(valid) >= $past($countones(valid)))
    else $error("tlb lost a valid entry");

  // A touch only reorders ages
  a_touch_keeps: assert property (@(posedge clk) disable iff (rst)
    (req.touch && rsp.hit) |=> $countones(valid) == $past($countones(valid)))
    else $error("tlb touch changed valid set");

  // After an insert at least one entry is valid
  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    (req.insert && !req.touch) |=> valid != '0)
    else $error("tlb insert left no valid entry");

endmodule

// ===== sv/segment_page_mmu_with_lru_tlb_top.sv =====
// ----------------------------------------------------------------------------
// segment_page_mmu_with_lru_tlb_top: segment/page MMU with LRU TLB
// Sequencer around the table memory, the frame bitmap memory and the TLB.
// ----------------------------------------------------------------------------
// One word is handled at a time. After reset the block runs a clearing pass
// over all 524288 words of the table memory before it takes its first word.
// A miss with resident tables makes two dependent reads of the single-port
// table memory: the segment word and then the page word. Set-up commands
// that mark frames read and write the frame bitmap once per frame marked. A
// write miss that allocates scans the frame bitmap one 32-frame word at a
// time (up to 32 words) and then clears the new frames at one table word per
// cycle: 1024 words for a page table pair, 512 for a page. A stalled result
// holds the block until it is taken.
module segment_page_mmu_with_lru_tlb_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [27:0] virtual_address,
  input  logic [8:0]  seg_index,
  input  logic [9:0]  page_index,
  input  logic signed [19:0] table_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [18:0] physical_address
);

  localparam int PA_W    = spmmu_pkg::PA_W;
  localparam int WORD_W  = spmmu_pkg::WORD_W;
  localparam int MAP_W   = spmmu_pkg::MAP_W;
  localparam int MAP_AW  = spmmu_pkg::MAP_AW;
  localparam int MAP_BW  = spmmu_pkg::MAP_BW;
  localparam int FRAME_W = spmmu_pkg::FRAME_W;
  localparam int OFS_W   = spmmu_pkg::OFS_W;
  localparam int PAGE_W  = spmmu_pkg::PAGE_W;
  localparam int SEG_W   = spmmu_pkg::SEG_W;
  localparam int MAP_WORDS = spmmu_pkg::FRAME_COUNT / MAP_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ISSUE, S_SEG, S_PG_RD, S_PAGE, S_WR_PAGE, S_WR_SEG,
    S_A_RD, S_A_EVAL, S_A_MARK2, S_A_CLR, S_M_RD, S_M_WR, S_DONE
  } state_t;

  state_t                  state;
  spmmu_pkg::cmd_t         cmd_r;
  logic [27:0]             va_r;
  logic [SEG_W-1:0]        seg_r;
  logic [PAGE_W-1:0]       page_r;
  logic [WORD_W-1:0]       val_r;
  logic [WORD_W-1:0]       st_r;
  spmmu_pkg::status_t      res_status;
  logic [PA_W-1:0]         res_pa;
  logic [PA_W-1:0]         clr_cnt;
  logic                    a_pair;
  logic [MAP_AW-1:0]       a_widx;
  logic [MAP_W-1:0]        a_prev;
  logic [PA_W-1:0]         a_base;
  logic [FRAME_W-1:0]      a_cnt;
  logic [FRAME_W-1:0]      mfr;
  logic                    mark_two;

  // Table memory port
  logic                    t_we;
  logic [PA_W-1:0]         t_addr;
  logic [WORD_W-1:0]       t_wdata, t_rdata;

  // Frame bitmap port
  logic                    m_we;
  logic [MAP_AW-1:0]       m_addr;
  logic [MAP_W-1:0]        m_wdata, m_rdata;

  spmmu_pkg::tlb_req_t     tlb_req;
  spmmu_pkg::tlb_rsp_t     tlb_rsp;

  // Decoded fields
  logic                    is_xlate;
  logic [SEG_W-1:0]        cur_seg;
  logic [PAGE_W-1:0]       cur_page;
  logic [OFS_W-1:0]        ofs;
  logic [WORD_W-1:0]       seg_sum;
  logic [WORD_W-1:0]       pg_sum;
  logic                    rd_neg1, rd_zero, rd_bad;
  logic                    f_neg1, f_bad, f_pos;
  logic                    seg_reject;

  assign is_xlate = (cmd_r == spmmu_pkg::CMD_READ) || (cmd_r == spmmu_pkg::CMD_WRITE);
  assign cur_seg  = is_xlate ? va_r[27:19] : seg_r;
  assign cur_page = is_xlate ? va_r[18:9] : page_r;
  assign ofs      = va_r[8:0];

  // Table word just read: page table base check
  assign seg_sum  = {1'b0, t_rdata[PA_W-1:0]} + {{(WORD_W-PAGE_W){1'b0}}, cur_page};
  assign pg_sum   = {1'b0, st_r[PA_W-1:0]} + {{(WORD_W-PAGE_W){1'b0}}, cur_page};
  assign rd_neg1  = (t_rdata == '1);
  assign rd_zero  = (t_rdata == '0);
  assign rd_bad   = t_rdata[WORD_W-1] && !rd_neg1;

  // Set-up value checks
  assign f_neg1     = (val_r == '1);
  assign f_bad      = val_r[WORD_W-1] && !f_neg1;
  assign f_pos      = !val_r[WORD_W-1] && (val_r != '0);
  assign seg_reject = f_bad
                   || (f_pos && (val_r[PA_W-1:OFS_W] == '0))
                   || (!val_r[WORD_W-1] && (val_r[PA_W-1:OFS_W] == '1));

  // Allocation search over one bitmap word
  logic [MAP_W-1:0]   free;
  logic [MAP_W-1:0]   cand;
  logic [MAP_BW-1:0]  a_j;
  logic               straddle, a_found;
  logic [FRAME_W-1:0] a_k;
  logic [MAP_W-1:0]   a_newword;

  assign free     = ~m_rdata;
  assign straddle = a_pair && (a_widx != '0) && !a_prev[MAP_W-1] && free[0];
  assign cand     = a_pair ? {1'b0, free[MAP_W-2:0] & free[MAP_W-1:1]} : free;

  always_comb begin
    a_j = '0;
    for (int i = MAP_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        a_j = MAP_BW'(i);
      end
    end
  end

  assign a_found   = straddle || (|cand);
  assign a_k       = straddle ? {a_widx - 1'b1, {MAP_BW{1'b1}}} : {a_widx, a_j};
  assign a_newword = straddle ? (m_rdata | MAP_W'(1))
                   : a_pair   ? (m_rdata | (MAP_W'(3) << a_j))
                   :            (m_rdata | (MAP_W'(1) << a_j));

  // Table memory access
  always_comb begin
    t_we    = 1'b0;
    t_addr  = '0;
    t_wdata = '0;
    case (state)
      S_CLEAR: begin
        t_we   = 1'b1;
        t_addr = clr_cnt;
      end
      S_ISSUE: begin
        t_addr  = {{(PA_W-SEG_W){1'b0}}, cur_seg};
        t_we    = (cmd_r == spmmu_pkg::CMD_SET_SEG) && !seg_reject;
        t_wdata = val_r;
      end
      S_PG_RD: t_addr = pg_sum[PA_W-1:0];
      S_WR_PAGE: begin
        t_we    = 1'b1;
        t_addr  = pg_sum[PA_W-1:0];
        t_wdata = val_r;
      end
      S_WR_SEG: begin
        t_we    = 1'b1;
        t_addr  = {{(PA_W-SEG_W){1'b0}}, cur_seg};
        t_wdata = st_r;
      end
      S_A_CLR: begin
        t_we   = 1'b1;
        t_addr = a_base + {{(PA_W-FRAME_W){1'b0}}, a_cnt};
      end
      default: ;
    endcase
  end

  // Frame bitmap access
  always_comb begin
    m_we    = 1'b0;
    m_addr  = '0;
    m_wdata = '0;
    case (state)
      S_CLEAR: begin
        m_we    = (clr_cnt[PA_W-1:MAP_AW] == '0);
        m_addr  = clr_cnt[MAP_AW-1:0];
        m_wdata = (clr_cnt[MAP_AW-1:0] == '0) ? MAP_W'(1) : '0;
      end
      S_A_RD:   m_addr = a_widx;
      S_A_EVAL: begin
        m_we    = a_found;
        m_addr  = a_widx;
        m_wdata = a_newword;
      end
      S_A_MARK2: begin
        m_we    = 1'b1;
        m_addr  = a_widx - 1'b1;
        m_wdata = a_prev | {1'b1, {(MAP_W-1){1'b0}}};
      end
      S_M_RD: m_addr = mfr[FRAME_W-1:MAP_BW];
      S_M_WR: begin
        m_we    = 1'b1;
        m_addr  = mfr[FRAME_W-1:MAP_BW];
        m_wdata = m_rdata | (MAP_W'(1) << mfr[MAP_BW-1:0]);
      end
      default: ;
    endcase
  end

  // TLB control
  always_comb begin
    tlb_req.key    = va_r[27:9];
    tlb_req.touch  = (state == S_SEG) && is_xlate && !rd_bad
                  && !(!t_rdata[WORD_W-1] && seg_sum[WORD_W-1]);
    tlb_req.insert = is_xlate && (((state == S_PAGE) && !t_rdata[WORD_W-1] && !rd_zero)
                  || (state == S_WR_PAGE));
    tlb_req.frame  = (state == S_PAGE) ? t_rdata[PA_W-1:0] : val_r[PA_W-1:0];
  end

  spmmu_ram #(.ADDR_W(PA_W), .DATA_W(WORD_W)) u_table (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wdata), .rdata(t_rdata)
  );

  spmmu_ram #(.ADDR_W(MAP_AW), .DATA_W(MAP_W)) u_frame_map (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  spmmu_tlb u_tlb (.clk(clk), .rst(rst), .req(tlb_req), .rsp(tlb_rsp));

  assign in_stall = (state != S_IDLE);

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // result taken; S_DONE loads the next one itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= spmmu_pkg::cmd_t'(command);
            va_r   <= virtual_address;
            seg_r  <= seg_index;
            page_r <= page_index;
            val_r  <= table_value;
            res_pa <= '0;
            state  <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (cmd_r == spmmu_pkg::CMD_SET_SEG) begin
            if (seg_reject) begin
              res_status <= spmmu_pkg::ST_SET_REJECT;
              state      <= S_DONE;
            end else if (f_pos) begin
              mfr      <= val_r[PA_W-1:OFS_W];
              mark_two <= 1'b1;
              state    <= S_M_RD;
            end else begin
              res_status <= spmmu_pkg::ST_SET_DONE;
              state      <= S_DONE;
            end
          end else begin
            state <= S_SEG;
          end
        end
        S_SEG: begin
          st_r <= t_rdata;
          if (!is_xlate) begin
            if (t_rdata[WORD_W-1] || rd_zero || seg_sum[WORD_W-1] || f_bad) begin
              res_status <= spmmu_pkg::ST_SET_REJECT;
              state      <= S_DONE;
            end else begin
              state <= S_WR_PAGE;
            end
          end else if (rd_bad || (!t_rdata[WORD_W-1] && seg_sum[WORD_W-1])) begin
            res_status <= spmmu_pkg::ST_ERROR;
            state      <= S_DONE;
          end else if (tlb_rsp.hit) begin
            res_status <= spmmu_pkg::ST_HIT;
            res_pa     <= tlb_rsp.frame + {{(PA_W-OFS_W){1'b0}}, ofs};
            state      <= S_DONE;
          end else if (rd_neg1) begin
            res_status <= spmmu_pkg::ST_FAULT;
            state      <= S_DONE;
          end else if (rd_zero) begin
            if (cmd_r == spmmu_pkg::CMD_READ) begin
              res_status <= spmmu_pkg::ST_ERROR;
              state      <= S_DONE;
            end else begin
              a_pair <= 1'b1;
              a_widx <= '0;
              state  <= S_A_RD;
            end
          end else begin
            state <= S_PG_RD;
          end
        end
        S_PG_RD: state <= S_PAGE;
        S_PAGE: begin
          if (rd_neg1) begin
            res_status <= spmmu_pkg::ST_FAULT;
            state      <= S_DONE;
          end else if (t_rdata[WORD_W-1]) begin
            res_status <= spmmu_pkg::ST_ERROR;
            state      <= S_DONE;
          end else if (rd_zero) begin
            if (cmd_r == spmmu_pkg::CMD_READ) begin
              res_status <= spmmu_pkg::ST_ERROR;
              state      <= S_DONE;
            end else begin
              a_pair <= 1'b0;
              a_widx <= '0;
              state  <= S_A_RD;
            end
          end else begin
            res_status <= spmmu_pkg::ST_MISS;
            res_pa     <= t_rdata[PA_W-1:0] + {{(PA_W-OFS_W){1'b0}}, ofs};
            state      <= S_DONE;
          end
        end
        S_WR_PAGE: begin
          if (is_xlate) begin
            res_status <= spmmu_pkg::ST_MISS;
            res_pa     <= val_r[PA_W-1:0] + {{(PA_W-OFS_W){1'b0}}, ofs};
            state      <= S_DONE;
          end else if (f_pos) begin
            mfr      <= val_r[PA_W-1:OFS_W];
            mark_two <= 1'b0;
            state    <= S_M_RD;
          end else begin
            res_status <= spmmu_pkg::ST_SET_DONE;
            state      <= S_DONE;
          end
        end
        S_WR_SEG: begin
          // page table in place; now the page itself
          a_pair <= 1'b0;
          a_widx <= '0;
          state  <= S_A_RD;
        end
        S_A_RD: state <= S_A_EVAL;
        S_A_EVAL: begin
          if (a_found) begin
            a_base <= {a_k, {OFS_W{1'b0}}};
            a_cnt  <= '0;
            state  <= straddle ? S_A_MARK2 : S_A_CLR;
          end else begin
            a_prev <= m_rdata;
            if (a_widx == MAP_AW'(MAP_WORDS - 1)) begin
              res_status <= spmmu_pkg::ST_ERROR;
              state      <= S_DONE;
            end else begin
              a_widx <= a_widx + 1'b1;
              state  <= S_A_RD;
            end
          end
        end
        S_A_MARK2: state <= S_A_CLR;
        S_A_CLR: begin
          a_cnt <= a_cnt + 1'b1;
          if (a_cnt == (a_pair ? FRAME_W'(2 * spmmu_pkg::FRAME_WORDS - 1)
                               : FRAME_W'(spmmu_pkg::FRAME_WORDS - 1))) begin
            if (a_pair) begin
              st_r  <= {1'b0, a_base};
              state <= S_WR_SEG;
            end else begin
              val_r <= {1'b0, a_base};
              state <= S_WR_PAGE;
            end
          end
        end
        S_M_RD: state <= S_M_WR;
        S_M_WR: begin
          if (mark_two) begin
            mfr      <= mfr + 1'b1;
            mark_two <= 1'b0;
            state    <= S_M_RD;
          end else begin
            res_status <= spmmu_pkg::ST_SET_DONE;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid        <= 1'b1;
            status           <= res_status;
            physical_address <= res_pa;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // One word in flight: an accepted word closes the input
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while busy");

  // Only translations carry an address
  a_pa_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != spmmu_pkg::ST_HIT) && (status != spmmu_pkg::ST_MISS))
      |-> (physical_address == '0))
    else $error("address on a non-translation result");

  // Nothing accepted until the clearing pass is over
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("word accepted during clearing pass");

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for segment_page_mmu_with_lru_tlb_top
// Drives translate and table set-up words through the valid/stall input and
// checks each result word against a cycle-free model of the segment/page
// walk, frame allocator and four-entry LRU TLB kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 1200000;   // covers the clearing pass after reset

  localparam int WORD_W       = spmmu_pkg::WORD_W;
  localparam int PA_W         = spmmu_pkg::PA_W;
  localparam int KEY_W        = spmmu_pkg::KEY_W;
  localparam int AGE_W        = spmmu_pkg::AGE_W;
  localparam int VA_W         = spmmu_pkg::VA_W;
  localparam int OFS_W        = spmmu_pkg::OFS_W;
  localparam int SEG_W        = spmmu_pkg::SEG_W;
  localparam int PAGE_W       = spmmu_pkg::PAGE_W;
  localparam int FRAME_COUNT  = spmmu_pkg::FRAME_COUNT;
  localparam int FRAME_WORDS  = spmmu_pkg::FRAME_WORDS;
  localparam int MEMORY_WORDS = spmmu_pkg::MEMORY_WORDS;
  localparam int TLB_ENTRIES  = spmmu_pkg::TLB_ENTRIES;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        command = '0;
  logic [27:0]       virtual_address = '0;
  logic [8:0]        seg_index = '0;
  logic [9:0]        page_index = '0;
  logic signed [19:0] table_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        status;
  logic [18:0]       physical_address;

  segment_page_mmu_with_lru_tlb_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .virtual_address(virtual_address),
    .seg_index(seg_index), .page_index(page_index), .table_value(table_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .physical_address(physical_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench-side copy of the translation state
  logic [WORD_W-1:0] tbl_words [int];      // missing key reads as zero
  bit                frame_used [FRAME_COUNT];
  bit                tlb_v [TLB_ENTRIES];
  logic [KEY_W-1:0]  tlb_k [TLB_ENTRIES];
  logic [PA_W-1:0]   tlb_f [TLB_ENTRIES];
  logic [AGE_W-1:0]  tlb_a [TLB_ENTRIES];

  // Expected result words, oldest first
  spmmu_pkg::status_t want_status [$];
  logic [PA_W-1:0]    want_pa [$];

  int  errors = 0;
  bit  calm = 1'b0;          // no idling on either side
  int  hold_req = 0;         // receiver hold-off request, in cycles
  int  idle_cycles = 0;

  function automatic int tbl_rd(int a);
    logic [WORD_W-1:0] w;
    w = '0;
    if (tbl_words.exists(a % MEMORY_WORDS)) w = tbl_words[a % MEMORY_WORDS];
    return $signed(w);
  endfunction

  function automatic void tbl_wr(int a, int v);
    tbl_words[a % MEMORY_WORDS] = v[WORD_W-1:0];
  endfunction

  function automatic void mark_frame(int fr);
    if (fr >= 0 && fr < FRAME_COUNT) frame_used[fr] = 1'b1;
  endfunction

  // Lowest free frame (or adjacent pair), cleared; -1 when none left
  function automatic int grab_frames(bit pair);
    int last;
    int k;
    int n;
    last = pair ? FRAME_COUNT - 2 : FRAME_COUNT - 1;
    for (k = 0; k <= last; k++) begin
      if (!frame_used[k] && (!pair || !frame_used[k+1])) begin
        frame_used[k] = 1'b1;
        if (pair) frame_used[k+1] = 1'b1;
        for (n = 0; n < FRAME_WORDS * (pair ? 2 : 1); n++)
          tbl_words.delete(k * FRAME_WORDS + n);
        return k * FRAME_WORDS;
      end
    end
    return -1;
  endfunction

  // Aging insert: fills the first free slot, replacing every age-0 entry met before it
  function automatic void tlb_fill(logic [KEY_W-1:0] key, logic [PA_W-1:0] fr);
    int i;
    for (i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_v[i]) begin
        if (tlb_a[i] == 0) begin
          tlb_a[i] = 3; tlb_k[i] = key; tlb_f[i] = fr;
        end else begin
          tlb_a[i] = tlb_a[i] - 1;
        end
      end else begin
        tlb_v[i] = 1'b1; tlb_a[i] = 3; tlb_k[i] = key; tlb_f[i] = fr;
        return;
      end
    end
  endfunction

  function automatic void tlb_refresh(int hit);
    int j;
    for (j = 0; j < TLB_ENTRIES; j++)
      if (tlb_v[j] && tlb_a[j] > tlb_a[hit]) tlb_a[j] = tlb_a[j] - 1;
    tlb_a[hit] = 3;
  endfunction

  function automatic spmmu_pkg::status_t walk_tables(logic [VA_W-1:0] va, bit wr,
                                                     output logic [PA_W-1:0] pa);
    int s;
    int p;
    int st;
    int pt;
    int i;
    logic [OFS_W-1:0] ofs;
    logic [KEY_W-1:0] key;
    pa = '0;
    s = va[27:19];
    p = va[18:9];
    ofs = va[8:0];
    key = va[27:9];
    st = tbl_rd(s);
    if (st < -1 || (st >= 0 && st + p >= MEMORY_WORDS)) return spmmu_pkg::ST_ERROR;
    for (i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_v[i] && tlb_k[i] == key) begin
        tlb_refresh(i);
        pa = tlb_f[i] + ofs;
        return spmmu_pkg::ST_HIT;
      end
    end
    if (st == -1) return spmmu_pkg::ST_FAULT;
    if (st == 0) begin
      if (!wr) return spmmu_pkg::ST_ERROR;
      st = grab_frames(1'b1);
      if (st < 0) return spmmu_pkg::ST_ERROR;
      tbl_wr(s, st);
    end
    pt = tbl_rd(st + p);
    if (pt == -1) return spmmu_pkg::ST_FAULT;
    if (pt < -1) return spmmu_pkg::ST_ERROR;
    if (pt == 0) begin
      if (!wr) return spmmu_pkg::ST_ERROR;
      pt = grab_frames(1'b0);
      if (pt < 0) return spmmu_pkg::ST_ERROR;
      tbl_wr(st + p, pt);
    end
    tlb_fill(key, pt[PA_W-1:0]);
    pa = pt[PA_W-1:0] + ofs;
    return spmmu_pkg::ST_MISS;
  endfunction

  function automatic spmmu_pkg::status_t apply_word(spmmu_pkg::cmd_t c,
                                                    logic [VA_W-1:0] va, int s, int p,
                                                    int f, output logic [PA_W-1:0] pa);
    int st;
    pa = '0;
    case (c)
      spmmu_pkg::CMD_READ:  return walk_tables(va, 1'b0, pa);
      spmmu_pkg::CMD_WRITE: return walk_tables(va, 1'b1, pa);
      spmmu_pkg::CMD_SET_SEG: begin
        if (f < -1 || (f > 0 && f < FRAME_WORDS) || f / FRAME_WORDS >= FRAME_COUNT - 1)
          return spmmu_pkg::ST_SET_REJECT;
        tbl_wr(s, f);
        if (f > 0) begin
          mark_frame(f / FRAME_WORDS);
          mark_frame(f / FRAME_WORDS + 1);
        end
        return spmmu_pkg::ST_SET_DONE;
      end
      default: begin
        st = tbl_rd(s);
        if (st <= 0 || st + p >= MEMORY_WORDS || f < -1) return spmmu_pkg::ST_SET_REJECT;
        tbl_wr(st + p, f);
        if (f > 0) mark_frame(f / FRAME_WORDS);
        return spmmu_pkg::ST_SET_DONE;
      end
    endcase
  endfunction

  function automatic logic [VA_W-1:0] make_va(int s, int p, int o);
    return {s[SEG_W-1:0], p[PAGE_W-1:0], o[OFS_W-1:0]};
  endfunction

  // Send one word, wait for accept, then record the expected result
  task automatic send_word(spmmu_pkg::cmd_t c, logic [VA_W-1:0] va, int s = 0, int p = 0,
                           int f = 0);
    int gap;
    int r;
    logic [PA_W-1:0] pa;
    spmmu_pkg::status_t st;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(10, 40);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= c;
    virtual_address <= va;
    seg_index <= s[SEG_W-1:0];
    page_index <= p[PAGE_W-1:0];
    table_value <= f[WORD_W-1:0];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    st = apply_word(c, va, s[SEG_W-1:0], p[PAGE_W-1:0], f, pa);
    want_status.push_back(st);
    want_pa.push_back(pa);
  endtask

  // Sender stops offering and waits for every expected result
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (want_status.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, hold-off requests and the result check
  always @(posedge clk) begin : receiver
    int stall_left;
    spmmu_pkg::status_t ws;
    logic [PA_W-1:0] wp;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (want_status.size() == 0) begin
          $display("%0t: unexpected word status=%0d pa=%h", $time, status, physical_address);
          errors++;
        end else begin
          ws = want_status.pop_front();
          wp = want_pa.pop_front();
          if (status !== ws) begin
            $display("%0t: status expected %0d actual %0d", $time, ws, status);
            errors++;
          end
          if (physical_address !== wp) begin
            $display("%0t: physical_address expected %h actual %h", $time, wp,
                     physical_address);
            errors++;
          end
        end
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) < 3) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_entry(bit seg);
    case ($urandom_range(0, 9))
      0: return -1;
      1: return 0;
      2: return $signed(20'($urandom()));
      default: return seg ? $urandom_range(1, FRAME_COUNT - 2) * FRAME_WORDS
                          : $urandom_range(1, FRAME_COUNT - 1) * FRAME_WORDS;
    endcase
  endfunction

  // Field extremes, every command and the named corner cases
  task automatic test_directed_cases();
    send_word(spmmu_pkg::CMD_READ, make_va(0, 0, 0));       // absent segment read
    send_word(spmmu_pkg::CMD_WRITE, make_va(1, 2, 5));      // allocates pair and page
    send_word(spmmu_pkg::CMD_READ, make_va(1, 2, 9));       // TLB hit
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 2, 0, -1);
    send_word(spmmu_pkg::CMD_READ, make_va(2, 1, 1));       // segment fault
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 3, 0, 100);       // inside frame zero
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 3, 0, -5);        // below -1
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 3, 0,
              (FRAME_COUNT - 1) * FRAME_WORDS);             // last frame
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 3, 0, (FRAME_COUNT - 1) * FRAME_WORDS - 1);
    send_word(spmmu_pkg::CMD_READ, make_va(3, 600, 0));     // page table past memory
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 3, 600, 4096);   // target past memory
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 0, 1, 4096);     // segment absent
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 2, 1, 4096);     // segment faulted
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 4, 0, 10 * FRAME_WORDS);
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 4, 7, -1);
    send_word(spmmu_pkg::CMD_READ, make_va(4, 7, 3));       // page fault
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 4, 8, 524287);
    send_word(spmmu_pkg::CMD_READ, make_va(4, 8, 511));     // offset wraps
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 4, 8, 20 * FRAME_WORDS);
    send_word(spmmu_pkg::CMD_READ, make_va(4, 8, 511));     // stale TLB entry
    send_word(spmmu_pkg::CMD_SET_PAGE, '0, 4, 9, -2);       // value below -1
    send_word(spmmu_pkg::CMD_WRITE, make_va(4, 9, 0));      // page allocation only
    send_word(spmmu_pkg::CMD_READ, make_va(4, 10, 0));      // absent page read
    send_word(spmmu_pkg::CMD_READ, 28'hFFFFFFF);
  endtask

  // Mostly a small working set so the TLB hits and evicts; some noise
  task automatic test_random_traffic(int n);
    int i;
    int r;
    int s;
    int p;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 7);
      p = $urandom_range(0, 15);
      if (r < 40)
        send_word(spmmu_pkg::CMD_READ, make_va(s, p, $urandom_range(0, 511)));
      else if (r < 62)
        send_word(spmmu_pkg::CMD_WRITE, make_va(s, p, $urandom_range(0, 511)));
      else if (r < 80)
        send_word(spmmu_pkg::CMD_SET_PAGE, '0, s, p, pick_entry(1'b0));
      else if (r < 85)
        send_word(spmmu_pkg::CMD_SET_SEG, '0, s, 0, pick_entry(1'b1));
      else
        send_word(spmmu_pkg::cmd_t'($urandom_range(0, 3)), 28'($urandom()),
                  $urandom_range(0, 511), $urandom_range(0, 1023), pick_entry(r[0]));
    end
  endtask

  // Receiver holds off while the sender keeps offering, then a run with no idling on either side
  task automatic test_backpressure();
    hold_req = 400;
    test_random_traffic(40);
    wait_drained();
    calm = 1'b1;
    test_random_traffic(150);
    calm = 1'b0;
    wait_drained();
  endtask

  // Mark nearly every frame, leaving only one pair, then allocate past it
  task automatic test_frame_exhaustion();
    int k;
    for (k = 1; k <= 997; k += 2)
      send_word(spmmu_pkg::CMD_SET_SEG, '0, 300 + (k % 64), 0, k * FRAME_WORDS);
    for (k = 1001; k <= 1021; k += 2)
      send_word(spmmu_pkg::CMD_SET_SEG, '0, 300 + (k % 64), 0, k * FRAME_WORDS);
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 299, 0, 1022 * FRAME_WORDS);
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 5, 0, 0);
    send_word(spmmu_pkg::CMD_SET_SEG, '0, 6, 0, 0);
    send_word(spmmu_pkg::CMD_WRITE, make_va(5, 3, 7));   // table pair fits, page does not
    send_word(spmmu_pkg::CMD_WRITE, make_va(6, 3, 7));   // no pair left
    send_word(spmmu_pkg::CMD_WRITE, make_va(5, 4, 7));
    send_word(spmmu_pkg::CMD_READ, make_va(1, 2, 0));
  endtask

  initial begin
    frame_used[0] = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(500);
    test_backpressure();
    test_random_traffic(450);
    test_frame_exhaustion();
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
